// ===== rtl/core/local_maximum_3x3_detector_defines.svh =====
// assertion macros shared by the local maximum 3x3 detector rtl
// no dependencies; the asserting modules expect ports named clock and reset
`ifndef LOCAL_MAXIMUM_3X3_DETECTOR_DEFINES_SVH
`define LOCAL_MAXIMUM_3X3_DETECTOR_DEFINES_SVH

`ifndef NO_ASSERTIONS

// property that must hold at every clock edge out of reset
`define LMD_ASSERT(label, prop, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (prop)) else $error(msg);

// consequence that must hold in the cycle after the antecedent
`define LMD_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`else

`define LMD_ASSERT(label, prop, msg)
`define LMD_ASSERT_NEXT(label, ante, cons, msg)

`endif

`endif

// ===== rtl/core/lmd_pkg.sv =====
// shared types and constants of the local maximum 3x3 detector
// no dependencies; used by every module of the block but lmd_ram
package lmd_pkg;

   // frame limits and sample width
   localparam int MAX_COLUMNS = 1024;
   localparam int MAX_ROWS    = 4096;
   localparam int SAMPLE_BITS = 16;

   // derived widths
   localparam int COL_BITS       = $clog2(MAX_COLUMNS);
   localparam int CROW_BITS      = $clog2(MAX_ROWS);
   localparam int CFG_COL_BITS   = $clog2(MAX_COLUMNS + 1);
   localparam int CFG_ROW_BITS   = $clog2(MAX_ROWS + 1);
   localparam int ROW_BITS       = CFG_ROW_BITS;
   localparam int CSR_DATA_BITS  = (CFG_COL_BITS > CFG_ROW_BITS) ? CFG_COL_BITS : CFG_ROW_BITS;
   localparam int CSR_INDEX_BITS = 1;
   localparam int LINE_BITS      = 2 * SAMPLE_BITS;
   localparam int PEAK_BITS      = 23;

   // queue between the front and back ends
   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
   localparam int QCOUNT_BITS = $clog2(QUEUE_DEPTH + 1);

   // response queue
   localparam int OUT_DEPTH   = 2;
   localparam int OPTR_BITS   = $clog2(OUT_DEPTH);
   localparam int OCOUNT_BITS = $clog2(OUT_DEPTH + 1);

   // register indexes
   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_COLUMN_COUNT = 1'b0,
      CSR_ROW_COUNT    = 1'b1
   } csr_index_type;

   typedef logic signed [SAMPLE_BITS-1:0] sample_type;

   // window cells, indexed [row][column], column 2 is the newest
   typedef sample_type [2:0][2:0] window_type;

   // classification of one request
   typedef struct packed {
      logic                 dec_mid;    // decides the centre one column back
      logic                 dec_end;    // decides the centre at the end of the row
      logic                 left_mid;   // left neighbour exists for the middle centre
      logic                 up;         // row above the centres exists
      logic                 down;       // row below the centres exists
      logic                 restart;    // frame ends after this request
      logic [CROW_BITS-1:0] centre_row;
      logic [COL_BITS-1:0]  column;     // column of the request itself
   } item_info_type;

   // request held between accept and the line store update
   typedef struct packed {
      item_info_type info;
      sample_type    sample;
   } stage_type;

   // entry of the queue between front and back
   typedef struct packed {
      item_info_type info;
      window_type    win;
   } packet_type;

   // one decided centre
   typedef struct packed {
      logic                 is_peak;
      logic [CROW_BITS-1:0] centre_row;
      logic [COL_BITS-1:0]  centre_column;
      sample_type           centre_value;
      logic [PEAK_BITS-1:0] peaks_so_far;
      logic                 last_of_run;
   } result_type;

   // back end walk over the centres of one packet
   typedef enum logic {
      BACK_FIRST,
      BACK_SECOND
   } back_state_type;

endpackage

// ===== rtl/core/local_maximum_3x3_detector.sv =====
// Strict 3x3 local maximum detector over a raster stream of signed samples.
// Request channel: push/full; one sample or flush request per accepted edge,
// row by row, column_count per row, then one flush row after the last row.
// Result channel: empty/pop; a result is the oldest decided centre, with its
// position, value, running peak count and a mark on the last result of a request.
// Requests in the first row decide nothing; others past the first column decide the
// centre one column back, and the last request of a row also decides the row-end centre.
// Throughput: the back end takes one request per cycle while the result queue has room;
// a row-end request with two results walks both states, BACK_FIRST then BACK_SECOND,
// so rows of two or more columns fall below that rate; a four-entry queue absorbs it.
// Latency: a request passes the stage register, the queue and the result queue before
// its first result is visible; a row-end result is decided after the first one.
// Config: csr_write_enable/csr_index/csr_data write column_count and row_count;
// write them only while no request is in flight.
// Reset: synchronous; clears position, window, peak count and all queues, sets
// both counts to their maximum; the line stores hold no reset value.
// Stall: with pop low the results wait in a two-entry queue and the front end
// keeps taking requests until the queue behind it fills, then raises full.
// depends on lmd_pkg, lmd_front, lmd_queue and lmd_back
module local_maximum_3x3_detector import lmd_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_write_enable,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_data,
   input  logic                      req_push,
   output logic                      req_full,
   input  logic                      req_mode,
   input  sample_type                req_sample_value,
   output logic                      rsp_empty,
   input  logic                      rsp_pop,
   output logic                      rsp_is_peak,
   output logic [CROW_BITS-1:0]      rsp_centre_row,
   output logic [COL_BITS-1:0]       rsp_centre_column,
   output sample_type                rsp_centre_value,
   output logic [PEAK_BITS-1:0]      rsp_peaks_so_far,
   output logic                      rsp_last_of_run
);

   logic                   queue_push;
   packet_type             queue_data;
   logic                   queue_pop;
   logic                   queue_valid;
   packet_type             queue_head;
   logic [QCOUNT_BITS-1:0] queue_count;

   // position, line stores and window
   lmd_front u_front (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .req_push         (req_push),
      .req_full         (req_full),
      .req_mode         (req_mode),
      .req_sample_value (req_sample_value),
      .queue_count      (queue_count),
      .queue_push       (queue_push),
      .queue_data       (queue_data)
   );

   // decoupling queue
   lmd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (queue_push),
      .push_data  (queue_data),
      .pop        (queue_pop),
      .head_valid (queue_valid),
      .head       (queue_head),
      .count      (queue_count)
   );

   // decisions and results
   lmd_back u_back (
      .clock             (clock),
      .reset             (reset),
      .pkt_valid         (queue_valid),
      .pkt               (queue_head),
      .pkt_pop           (queue_pop),
      .rsp_empty         (rsp_empty),
      .rsp_pop           (rsp_pop),
      .rsp_is_peak       (rsp_is_peak),
      .rsp_centre_row    (rsp_centre_row),
      .rsp_centre_column (rsp_centre_column),
      .rsp_centre_value  (rsp_centre_value),
      .rsp_peaks_so_far  (rsp_peaks_so_far),
      .rsp_last_of_run   (rsp_last_of_run)
   );

endmodule

// ===== rtl/core/lmd_ram.sv =====
// generic single write port ram with one registered read port, read before write
// no dependencies
module lmd_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/core/lmd_queue.sv =====
// small register queue of classified windows between front and back ends
// depends on lmd_pkg
`include "local_maximum_3x3_detector_defines.svh"

module lmd_queue import lmd_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  packet_type             push_data,
   input  logic                   pop,
   output logic                   head_valid,
   output packet_type             head,
   output logic [QCOUNT_BITS-1:0] count
);

   packet_type             mem_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCOUNT_BITS-1:0] count_ff, count_in;

   // pointer and fill count
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // storage
   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign head_valid = (count_ff != '0);
   assign head       = mem_ff[rd_ptr_ff];
   assign count      = count_ff;

   `LMD_ASSERT(a_queue_no_overflow, !(push && !pop && count_ff == QCOUNT_BITS'(QUEUE_DEPTH)), "queue overflow")
   `LMD_ASSERT(a_queue_no_underflow, !(pop && count_ff == '0), "queue underflow")

endmodule

// ===== rtl/core/lmd_front.sv =====
// front end: configuration, raster position, line stores and the 3x3 window
// depends on lmd_pkg and lmd_ram
`include "local_maximum_3x3_detector_defines.svh"

module lmd_front import lmd_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_write_enable,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_data,
   input  logic                      req_push,
   output logic                      req_full,
   input  logic                      req_mode,
   input  sample_type                req_sample_value,
   input  logic [QCOUNT_BITS-1:0]    queue_count,
   output logic                      queue_push,
   output packet_type                queue_data
);

   logic [CFG_COL_BITS-1:0] col_count_ff, col_count_in;
   logic [CFG_ROW_BITS-1:0] row_count_ff, row_count_in;
   logic [COL_BITS-1:0]     col_ff, col_in;
   logic [ROW_BITS-1:0]     row_ff, row_in;
   logic                    stage_valid_ff, stage_valid_in;
   stage_type               stage_ff, stage_in;
   window_type              win_ff, win_in;
   logic                    fwd_hit_ff, fwd_hit_in;
   logic [LINE_BITS-1:0]    fwd_data_ff, fwd_data_in;

   logic                    accept;
   logic [CFG_COL_BITS-1:0] col_plus;
   logic                    end_of_row;
   logic                    row_down;
   logic                    row_live;
   logic [LINE_BITS-1:0]    ram_rd_data;
   logic [LINE_BITS-1:0]    line_rd;
   sample_type              older_rd;
   sample_type              newer_rd;

   // configuration registers, clamped on write
   always_comb begin
      col_count_in = col_count_ff;
      row_count_in = row_count_ff;
      if (csr_write_enable) begin
         unique case (csr_index_type'(csr_index))
            CSR_COLUMN_COUNT: begin
               if (csr_data == '0) begin
                  col_count_in = CFG_COL_BITS'(1);
               end else if (csr_data > CSR_DATA_BITS'(MAX_COLUMNS)) begin
                  col_count_in = CFG_COL_BITS'(MAX_COLUMNS);
               end else begin
                  col_count_in = csr_data[CFG_COL_BITS-1:0];
               end
            end
            CSR_ROW_COUNT: begin
               if (csr_data == '0) begin
                  row_count_in = CFG_ROW_BITS'(1);
               end else if (csr_data > CSR_DATA_BITS'(MAX_ROWS)) begin
                  row_count_in = CFG_ROW_BITS'(MAX_ROWS);
               end else begin
                  row_count_in = csr_data[CFG_ROW_BITS-1:0];
               end
            end
            default: begin
               col_count_in = col_count_ff;
            end
         endcase
      end
   end

   // accept only with room for the request already in flight
   assign req_full = (QCOUNT_BITS'(queue_count) + QCOUNT_BITS'(stage_valid_ff))
                     >= QCOUNT_BITS'(QUEUE_DEPTH);
   assign accept   = req_push && !req_full;

   // raster position of the incoming request
   assign col_plus   = CFG_COL_BITS'(col_ff) + CFG_COL_BITS'(1);
   assign end_of_row = (col_plus >= col_count_ff);
   assign row_down   = (row_ff < row_count_ff);
   assign row_live   = (row_ff != '0);

   // position counters
   always_comb begin
      col_in = col_ff;
      row_in = row_ff;
      if (accept) begin
         if (end_of_row) begin
            col_in = '0;
            row_in = row_down ? ROW_BITS'(row_ff + 1'b1) : '0;
         end else begin
            col_in = col_plus[COL_BITS-1:0];
         end
      end
   end

   // classify the request
   always_comb begin
      stage_valid_in            = accept;
      stage_in                  = stage_ff;
      if (accept) begin
         stage_in.sample          = req_mode ? '0 : req_sample_value;
         stage_in.info.dec_mid    = row_live && (col_ff != '0);
         stage_in.info.dec_end    = row_live && end_of_row;
         stage_in.info.left_mid   = (col_ff > COL_BITS'(1));
         stage_in.info.up         = (row_ff > ROW_BITS'(1));
         stage_in.info.down       = row_down;
         stage_in.info.restart    = end_of_row && !row_down;
         stage_in.info.centre_row = CROW_BITS'(row_ff - 1'b1);
         stage_in.info.column     = col_ff;
      end
   end

   // line stores, older and newer row side by side
   lmd_ram #(
      .WIDTH (LINE_BITS),
      .DEPTH (MAX_COLUMNS)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (stage_valid_ff),
      .wr_addr (stage_ff.info.column),
      .wr_data ({newer_rd, stage_ff.sample}),
      .rd_en   (accept),
      .rd_addr (col_ff),
      .rd_data (ram_rd_data)
   );

   // bypass a write that landed on the same edge as the read
   assign line_rd  = fwd_hit_ff ? fwd_data_ff : ram_rd_data;
   assign older_rd = line_rd[LINE_BITS-1:SAMPLE_BITS];
   assign newer_rd = line_rd[SAMPLE_BITS-1:0];

   always_comb begin
      fwd_hit_in  = stage_valid_ff && accept && (stage_ff.info.column == col_ff);
      fwd_data_in = {newer_rd, stage_ff.sample};
   end

   // window shift
   always_comb begin
      win_in = win_ff;
      if (stage_valid_ff) begin
         for (int r = 0; r < 3; r++) begin
            win_in[r][0] = win_ff[r][1];
            win_in[r][1] = win_ff[r][2];
         end
         win_in[0][2] = older_rd;
         win_in[1][2] = newer_rd;
         win_in[2][2] = stage_ff.sample;
      end
   end

   assign queue_push      = stage_valid_ff;
   assign queue_data.info = stage_ff.info;
   assign queue_data.win  = win_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         col_count_ff   <= CFG_COL_BITS'(MAX_COLUMNS);
         row_count_ff   <= CFG_ROW_BITS'(MAX_ROWS);
         col_ff         <= '0;
         row_ff         <= '0;
         stage_valid_ff <= 1'b0;
         win_ff         <= '0;
         fwd_hit_ff     <= 1'b0;
      end else begin
         col_count_ff   <= col_count_in;
         row_count_ff   <= row_count_in;
         col_ff         <= col_in;
         row_ff         <= row_in;
         stage_valid_ff <= stage_valid_in;
         win_ff         <= win_in;
         fwd_hit_ff     <= fwd_hit_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      stage_ff    <= stage_in;
      fwd_data_ff <= fwd_data_in;
   end

   `LMD_ASSERT_NEXT(a_front_accept_staged, accept, stage_valid_ff, "accepted request not staged")

endmodule

// ===== rtl/core/lmd_back.sv =====
// back end: decides centres of queued windows, keeps the peak count, result queue
// depends on lmd_pkg
`include "local_maximum_3x3_detector_defines.svh"

module lmd_back import lmd_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   pkt_valid,
   input  packet_type             pkt,
   output logic                   pkt_pop,
   output logic                   rsp_empty,
   input  logic                   rsp_pop,
   output logic                   rsp_is_peak,
   output logic [CROW_BITS-1:0]   rsp_centre_row,
   output logic [COL_BITS-1:0]    rsp_centre_column,
   output sample_type             rsp_centre_value,
   output logic [PEAK_BITS-1:0]   rsp_peaks_so_far,
   output logic                   rsp_last_of_run
);

   back_state_type          state_ff, state_in;
   logic [PEAK_BITS-1:0]    peak_ff, peak_in;
   result_type              out_mem_ff [OUT_DEPTH];
   logic [OPTR_BITS-1:0]    out_wr_ff, out_wr_in;
   logic [OPTR_BITS-1:0]    out_rd_ff, out_rd_in;
   logic [OCOUNT_BITS-1:0]  out_count_ff, out_count_in;

   logic                    second;
   logic                    emit;
   logic                    done;
   logic                    step;
   logic                    out_push;
   logic                    out_pop;
   logic                    is_peak;
   result_type              result;

   // which centre of the packet is up
   always_comb begin
      second = (state_ff == BACK_SECOND) || !pkt.info.dec_mid;
      emit   = second ? pkt.info.dec_end : pkt.info.dec_mid;
      done   = second || !pkt.info.dec_end;
      step   = pkt_valid && (!emit || (out_count_ff != OCOUNT_BITS'(OUT_DEPTH)));
   end

   // next state
   always_comb begin
      state_in = state_ff;
      if (step) begin
         unique case (state_ff)
            BACK_FIRST:  state_in = done ? BACK_FIRST : BACK_SECOND;
            BACK_SECOND: state_in = BACK_FIRST;
            default:     state_in = BACK_FIRST;
         endcase
      end
   end

   // outputs of the walk
   always_comb begin
      pkt_pop  = step && done;
      out_push = step && emit;
   end

   // strict maximum over the neighbours that exist
   always_comb begin
      sample_type lc [3];
      sample_type cc [3];
      sample_type rc [3];
      logic       left;
      logic       right;
      logic       row_on;
      for (int r = 0; r < 3; r++) begin
         lc[r] = second ? pkt.win[r][1] : pkt.win[r][0];
         cc[r] = second ? pkt.win[r][2] : pkt.win[r][1];
         rc[r] = pkt.win[r][2];
      end
      left    = second ? (pkt.info.column != '0) : pkt.info.left_mid;
      right   = !second;
      is_peak = 1'b1;
      for (int r = 0; r < 3; r++) begin
         row_on = (r == 0) ? pkt.info.up : ((r == 2) ? pkt.info.down : 1'b1);
         if (row_on && left && (lc[r] >= cc[1])) begin
            is_peak = 1'b0;
         end
         if (row_on && (r != 1) && (cc[r] >= cc[1])) begin
            is_peak = 1'b0;
         end
         if (row_on && right && (rc[r] >= cc[1])) begin
            is_peak = 1'b0;
         end
      end
   end

   // result record
   always_comb begin
      result.is_peak       = is_peak;
      result.centre_row    = pkt.info.centre_row;
      result.centre_column = second ? pkt.info.column : COL_BITS'(pkt.info.column - 1'b1);
      result.centre_value  = second ? pkt.win[1][2] : pkt.win[1][1];
      result.peaks_so_far  = is_peak ? PEAK_BITS'(peak_ff + 1'b1) : peak_ff;
      result.last_of_run   = done;
   end

   // peak count, cleared once the last request of a frame is done
   always_comb begin
      peak_in = peak_ff;
      if (out_push) begin
         peak_in = result.peaks_so_far;
      end
      if (pkt_pop && pkt.info.restart) begin
         peak_in = '0;
      end
   end

   // result queue
   assign out_pop = rsp_pop && !rsp_empty;

   always_comb begin
      out_wr_in    = out_wr_ff;
      out_rd_in    = out_rd_ff;
      out_count_in = out_count_ff;
      if (out_push) begin
         out_wr_in = (out_wr_ff == OPTR_BITS'(OUT_DEPTH - 1)) ? '0 : out_wr_ff + 1'b1;
      end
      if (out_pop) begin
         out_rd_in = (out_rd_ff == OPTR_BITS'(OUT_DEPTH - 1)) ? '0 : out_rd_ff + 1'b1;
      end
      if (out_push && !out_pop) begin
         out_count_in = out_count_ff + 1'b1;
      end else if (out_pop && !out_push) begin
         out_count_in = out_count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BACK_FIRST;
         peak_ff      <= '0;
         out_wr_ff    <= '0;
         out_rd_ff    <= '0;
         out_count_ff <= '0;
      end else begin
         state_ff     <= state_in;
         peak_ff      <= peak_in;
         out_wr_ff    <= out_wr_in;
         out_rd_ff    <= out_rd_in;
         out_count_ff <= out_count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (out_push) begin
         out_mem_ff[out_wr_ff] <= result;
      end
   end

   assign rsp_empty         = (out_count_ff == '0);
   assign rsp_is_peak       = out_mem_ff[out_rd_ff].is_peak;
   assign rsp_centre_row    = out_mem_ff[out_rd_ff].centre_row;
   assign rsp_centre_column = out_mem_ff[out_rd_ff].centre_column;
   assign rsp_centre_value  = out_mem_ff[out_rd_ff].centre_value;
   assign rsp_peaks_so_far  = out_mem_ff[out_rd_ff].peaks_so_far;
   assign rsp_last_of_run   = out_mem_ff[out_rd_ff].last_of_run;

   `LMD_ASSERT(a_back_second_has_both, (state_ff != BACK_SECOND) || (pkt_valid && pkt.info.dec_mid && pkt.info.dec_end), "second centre without a two-result packet")
   `LMD_ASSERT(a_back_out_bound, out_count_ff <= OCOUNT_BITS'(OUT_DEPTH), "result queue overflow")

endmodule
